### sv/ilss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilss_pkg
// Shared types and constants for the indexed list shift store.
// ----------------------------------------------------------------------------
package ilss_pkg;

  localparam int MAX_RESULTS = 32;

  typedef enum logic [2:0] {
    OP_PREPEND = 3'd0,
    OP_APPEND  = 3'd1,
    OP_INSERT  = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_REVERSE = 3'd4,
    OP_GET     = 3'd5,
    OP_DUMP    = 3'd6,
    OP_NOP     = 3'd7
  } ilss_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } ilss_st_t;

  typedef struct packed {
    ilss_op_t           opcode;
    logic signed [31:0] value;
    logic        [4:0]  position;
  } ilss_in_t;

  typedef struct packed {
    logic signed [31:0] word;
    logic        [4:0]  word_index;
    logic        [5:0]  count;
    ilss_st_t           status;
    logic               last;
  } ilss_out_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic advance;
  } ilss_cmd_t;

  typedef struct packed {
    logic last;
  } ilss_sts_t;

endpackage

### sv/ilss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilss_ctrl
// Sequencer: accepts a word, runs an execute step for each result and holds
// each result until the output side takes it.
// ----------------------------------------------------------------------------
module ilss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output ilss_pkg::ilss_cmd_t cmd,
  input  ilss_pkg::ilss_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   take_out;

  always_comb begin
    take_out  = (state_r == S_OUT) && !out_stall;
    in_stall  = !((state_r == S_IDLE) || (take_out && sts.last));
    out_valid = (state_r == S_OUT);
    cmd.capture = in_valid && !in_stall;
    cmd.execute = (state_r == S_EXEC);
    cmd.advance = take_out && !sts.last;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (!sts.last || in_valid) state_nxt = S_EXEC;
          else state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/ilss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilss_dp
// Datapath: row of entry cells with neighbor shifts, fill count, reversal
// flag, read select and the result register.
// ----------------------------------------------------------------------------
module ilss_dp #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ilss_pkg::ilss_cmd_t cmd,
  input  ilss_pkg::ilss_in_t  in_data,
  output ilss_pkg::ilss_out_t out_data,
  output ilss_pkg::ilss_sts_t sts
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (CW > 6) ? CW : 6;

  logic signed [31:0]   cells_r   [DEPTH];
  logic signed [31:0]   cells_nxt [DEPTH];
  logic signed [31:0]   below_w   [DEPTH];
  logic signed [31:0]   above_w   [DEPTH];
  logic [CW-1:0]        count_r;
  logic                 rev_r;
  ilss_pkg::ilss_op_t   op_r;
  logic signed [31:0]   val_r;
  logic [4:0]           pos_r;
  logic [4:0]           didx_r;
  ilss_pkg::ilss_out_t  out_r;

  logic [IW-1:0]        n;
  logic [IW-1:0]        posx;
  logic [IW-1:0]        dx;
  logic [IW-1:0]        lim;
  logic [IW-1:0]        p;
  logic [IW-1:0]        qi;
  logic [IW-1:0]        rd_i;
  logic [IW-1:0]        cnt_nxt;
  logic                 rev_nxt;
  logic                 ins_en;
  logic                 rem_en;
  logic                 use_rd;
  logic [4:0]           res_idx;
  ilss_pkg::ilss_st_t   res_st;
  logic                 res_last;
  logic signed [31:0]   res_word;

  always_comb begin
    n        = IW'(count_r);
    posx     = IW'(pos_r);
    dx       = IW'(didx_r);
    lim      = (n < IW'(ilss_pkg::MAX_RESULTS)) ? n : IW'(ilss_pkg::MAX_RESULTS);
    p        = '0;
    qi       = '0;
    rd_i     = '0;
    cnt_nxt  = n;
    rev_nxt  = rev_r;
    ins_en   = 1'b0;
    rem_en   = 1'b0;
    use_rd   = 1'b0;
    res_idx  = '0;
    res_st   = ilss_pkg::ST_OK;
    res_last = 1'b1;
    unique case (op_r) inside
      ilss_pkg::OP_PREPEND, ilss_pkg::OP_APPEND, ilss_pkg::OP_INSERT: begin
        if (op_r == ilss_pkg::OP_PREPEND) p = '0;
        else if (op_r == ilss_pkg::OP_APPEND) p = n;
        else p = posx;
        if (n == IW'(DEPTH)) begin
          res_st = ilss_pkg::ST_FULL;
        end else if (p > n) begin
          res_st = ilss_pkg::ST_RANGE;
        end else begin
          ins_en  = 1'b1;
          qi      = rev_r ? (n - p) : p;
          cnt_nxt = n + IW'(1);
        end
      end
      ilss_pkg::OP_REMOVE: begin
        if (posx >= n) begin
          res_st = ilss_pkg::ST_RANGE;
        end else begin
          rem_en  = 1'b1;
          qi      = rev_r ? (n - IW'(1) - posx) : posx;
          cnt_nxt = n - IW'(1);
        end
      end
      ilss_pkg::OP_REVERSE: begin
        rev_nxt = !rev_r;
      end
      ilss_pkg::OP_GET: begin
        if (posx >= n) begin
          res_st = ilss_pkg::ST_RANGE;
        end else begin
          use_rd  = 1'b1;
          rd_i    = rev_r ? (n - IW'(1) - posx) : posx;
          res_idx = pos_r;
        end
      end
      ilss_pkg::OP_DUMP: begin
        if (n == '0) begin
          res_st = ilss_pkg::ST_EMPTY;
        end else begin
          use_rd   = 1'b1;
          rd_i     = rev_r ? (n - IW'(1) - dx) : dx;
          res_idx  = didx_r;
          res_last = ((dx + IW'(1)) == lim);
        end
      end
      default: begin
      end
    endcase
    res_word = use_rd ? cells_r[rd_i[AW-1:0]] : 32'sd0;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_bot
      assign below_w[g] = cells_r[g];
    end else begin : g_mid
      assign below_w[g] = cells_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign above_w[g] = cells_r[g];
    end else begin : g_low
      assign above_w[g] = cells_r[g+1];
    end

    always_comb begin
      cells_nxt[g] = cells_r[g];
      if (ins_en) begin
        if (IW'(g) == qi) cells_nxt[g] = val_r;
        else if (IW'(g) > qi) cells_nxt[g] = below_w[g];
      end else if (rem_en) begin
        if (IW'(g) >= qi) cells_nxt[g] = above_w[g];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.execute) cells_r[g] <= cells_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rev_r   <= 1'b0;
      didx_r  <= '0;
    end else begin
      if (cmd.execute) begin
        count_r <= cnt_nxt[CW-1:0];
        rev_r   <= rev_nxt;
      end
      if (cmd.capture) didx_r <= '0;
      else if (cmd.advance) didx_r <= didx_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data.opcode;
      val_r <= in_data.value;
      pos_r <= in_data.position;
    end
    if (cmd.execute) begin
      out_r.word       <= res_word;
      out_r.word_index <= res_idx;
      out_r.count      <= cnt_nxt[5:0];
      out_r.status     <= res_st;
      out_r.last       <= res_last;
    end
  end

  assign out_data = out_r;
  assign sts.last = out_r.last;

endmodule

### sv/indexed_list_shift_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_shift_store_core
// Ordered list of signed words with prepend, append, insert, remove,
// reverse, get and dump, reporting the new length with every result.
// ----------------------------------------------------------------------------
//  channel | ports                         | moves
//  in      | in_valid, in_stall, in_data   | one operation word
//  out     | out_valid, out_stall, out_data| one result word
//
//  An accepted operation word runs in the execute state; its result is then
//  held in the output state. A new operation is taken while idle or as the
//  last result word of the previous one is taken. A dump emits its results
//  one by one, up to 32 results. Insert and remove shift the cell row on
//  execute; reverse flips a flag. Reset clears the length and control.
//  A stalled result holds, and input stays stalled until it is taken.
// ----------------------------------------------------------------------------
module indexed_list_shift_store_core #(
  parameter int DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ilss_pkg::ilss_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ilss_pkg::ilss_out_t out_data
);

  ilss_pkg::ilss_cmd_t cmd;
  ilss_pkg::ilss_sts_t sts;

  ilss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ilss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data),
    .sts      (sts)
  );

endmodule

### sv/ilss_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilss_chk
// Port-level checks for the indexed list shift store.
// ----------------------------------------------------------------------------
module ilss_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ilss_pkg::ilss_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input ilss_pkg::ilss_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result word waits");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result word without execute cycle");

  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ilss_pkg::ST_OK) |->
      (out_data.word == 32'sd0) && (out_data.word_index == 5'd0) && out_data.last)
    else $error("failed operation word not clean");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |-> ##2
      out_valid && (out_data.word_index == 5'($past(out_data.word_index, 2) + 5'd1)))
    else $error("dump index did not advance");

endmodule

bind indexed_list_shift_store_core ilss_chk u_chk (.*);
